### rtl/core/dqfp_pkg.sv
`timescale 1ns / 1ps
package dqfp_pkg;
   localparam int MaxNameBytes = 255;
   localparam logic [15:0] DefaultPort = 16'd53;
   localparam logic [15:0] DnsStart = 16'd42;
   localparam logic [15:0] PosLimit = 16'hffff;
   localparam logic [8:0] NameLenLimit = 9'd511;

   typedef enum logic [2:0] {
      PH_HEADER, PH_LENGTH, PH_LABEL, PH_TAIL, PH_COMPLETE, PH_STOP
   } phase_type;

   typedef enum logic [3:0] {
      R_NONE = 4'd0, R_SHORT = 4'd1, R_ETH = 4'd2, R_IPHDR = 4'd3, R_CAST = 4'd4,
      R_PORT = 4'd5, R_LENGTH = 4'd6, R_QDCOUNT = 4'd7, R_LABEL = 4'd8,
      R_NAMEEND = 4'd9
   } reason_type;

   localparam logic CsrDirection = 1'b0;
   localparam logic CsrPort = 1'b1;

   typedef struct packed {
      logic          accepted;
      logic [3:0]    reject_reason;
      logic          cacheable;
      logic [15:0]   transaction_id;
      logic [15:0]   query_type;
      logic [15:0]   query_class;
      logic [8:0]    question_bytes;
   } rsp_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;
endpackage

### rtl/core/dqfp_if.sv
`timescale 1ns / 1ps
interface dqfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   modport source(output valid, frame_byte, last_byte, input ready);
   modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

interface dqfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [3:0]  reject_reason;
   logic        cacheable;
   logic [15:0] transaction_id;
   logic [15:0] query_type;
   logic [15:0] query_class;
   logic [8:0]  question_bytes;
   modport source(output valid, accepted, reject_reason, cacheable, transaction_id,
                  query_type, query_class, question_bytes, input ready);
   modport sink(input valid, accepted, reject_reason, cacheable, transaction_id,
                query_type, query_class, question_bytes, output ready);
endinterface

interface dqfp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

### rtl/core/dqfp_parse.sv
`timescale 1ns / 1ps
// Per-byte parse engine: frame state is updated as each byte is taken in,
// and on the last byte the verdict is formed from the updated state.
module dqfp_parse #(
   parameter int MAX_NAME_BYTES = dqfp_pkg::MaxNameBytes
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  dqfp_pkg::req_type    req,
   input  logic                 dir_resp,
   input  logic [15:0]          service_port,
   output dqfp_pkg::rsp_type    verdict,
   output logic                 verdict_valid
);
   import dqfp_pkg::*;

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  err_ff, err_in;
   logic [31:0] shift_ff, shift_in;
   logic [1:0]  mac_ff, mac_in;
   logic [15:0] iplen_ff, iplen_in, udplen_ff, udplen_in, flags_ff, flags_in;
   logic [2:0]  rcz_ff, rcz_in;
   logic [5:0]  lrem_ff, lrem_in;
   logic [8:0]  nlen_ff, nlen_in;
   logic [47:0] sq_ff, sq_in;

   logic [7:0]  b;
   logic [15:0] w, off, dsize, left, fsize;
   logic [31:0] a;
   logic        uni, bad;
   logic [3:0]  reason;
   logic [8:0]  nbump;
   logic        elig;
   logic [15:0] f;

   always_comb begin
      b = req.frame_byte;
      pos_in = pos_ff; phase_in = phase_ff; err_in = err_ff; shift_in = shift_ff;
      mac_in = mac_ff; iplen_in = iplen_ff; udplen_in = udplen_ff; flags_in = flags_ff;
      rcz_in = rcz_ff; lrem_in = lrem_ff; nlen_in = nlen_ff; sq_in = sq_ff;
      off = pos_ff - DnsStart;
      dsize = udplen_ff - 16'd8;
      left = dsize - off - 16'd1;
      a = {shift_ff[23:0], b};
      w = a[15:0];
      uni = (a != 32'd0) && (a < 32'he0000000 || a > 32'hefffffff) && (a != 32'hffffffff);
      bad = 1'b0;
      nbump = (nlen_ff < NameLenLimit) ? nlen_ff + 9'd1 : nlen_ff;
      if (pos_ff < PosLimit) begin
         shift_in = a;
         pos_in = pos_ff + 16'd1;
         if (pos_ff < DnsStart) begin
            if ((pos_ff == 16'd0 || pos_ff == 16'd6) && b[0] && err_in == R_NONE) err_in = R_ETH;
            if (pos_ff < 16'd6 && b != 8'd0) mac_in[0] = 1'b1;
            if (pos_ff >= 16'd6 && pos_ff < 16'd12 && b != 8'd0) mac_in[1] = 1'b1;
            if (pos_ff == 16'd11 && mac_in != 2'b11 && err_in == R_NONE) err_in = R_ETH;
            if (pos_ff == 16'd13 && w != 16'h0800 && err_in == R_NONE) err_in = R_ETH;
            if (pos_ff == 16'd14 && b != 8'h45 && err_in == R_NONE) err_in = R_IPHDR;
            if (pos_ff == 16'd17) iplen_in = w;
            if (pos_ff == 16'd21 && (w & 16'h3fff) != 16'd0 && err_in == R_NONE)
               err_in = R_IPHDR;
            if (pos_ff == 16'd23 && b != 8'd17 && err_in == R_NONE) err_in = R_IPHDR;
            if ((pos_ff == 16'd29 || pos_ff == 16'd33) && !dir_resp && !uni &&
                err_in == R_NONE) err_in = R_CAST;
            if (pos_ff == 16'd37) begin
               bad = !dir_resp ? (w != service_port || a[31:16] == 16'd0)
                               : (a[31:16] != service_port || w == 16'd0);
               if (bad && err_in == R_NONE) err_in = R_PORT;
            end
            if (pos_ff == 16'd39) begin
               udplen_in = w;
               if ((iplen_ff != w + 16'd20 || {1'b0, iplen_ff} != {1'b0, w} + 17'd20 ||
                    w < 16'd20) && err_in == R_NONE) err_in = R_LENGTH;
            end
         end else if (err_ff == R_NONE && off < dsize) begin
            if (off < 16'd12) begin
               if (off == 16'd1) sq_in = {w, 32'd0};
               else if (off == 16'd3) flags_in = w;
               else if (off == 16'd5 && w != 16'd1) err_in = R_QDCOUNT;
               else if (off == 16'd7 && w == 16'd0) rcz_in[0] = 1'b1;
               else if (off == 16'd9 && w == 16'd0) rcz_in[1] = 1'b1;
               else if (off == 16'd11) begin
                  if (w == 16'd0) rcz_in[2] = 1'b1;
                  phase_in = PH_LENGTH;
               end
            end else begin
               unique case (phase_ff)
                  PH_LENGTH: begin
                     nlen_in = nbump;
                     if ((b & 8'hc0) != 8'd0) begin
                        err_in = R_LABEL; phase_in = PH_STOP;
                     end else if (b == 8'd0) begin
                        if (left < 16'd4 || nbump > 9'(MAX_NAME_BYTES)) begin
                           err_in = R_NAMEEND; phase_in = PH_STOP;
                        end else begin
                           lrem_in = 6'd4; phase_in = PH_TAIL;
                        end
                     end else if ({8'd0, b} > left) begin
                        err_in = R_LABEL; phase_in = PH_STOP;
                     end else begin
                        lrem_in = b[5:0]; phase_in = PH_LABEL;
                     end
                  end
                  PH_LABEL: begin
                     nlen_in = nbump;
                     lrem_in = lrem_ff - 6'd1;
                     if (lrem_in == 6'd0) phase_in = PH_LENGTH;
                  end
                  PH_TAIL: begin
                     lrem_in = lrem_ff - 6'd1;
                     if (lrem_in == 6'd0) begin
                        sq_in = {sq_ff[47:32], a}; phase_in = PH_COMPLETE;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      fsize = pos_in;
      if (fsize < DnsStart) reason = R_SHORT;
      else if (err_in != R_NONE && err_in < R_QDCOUNT) reason = err_in;
      else if ({1'b0, udplen_in} + 17'd34 > {1'b0, fsize}) reason = R_LENGTH;
      else if (err_in != R_NONE) reason = err_in;
      else if (phase_in != PH_COMPLETE) reason = R_NAMEEND;
      else reason = R_NONE;
      f = flags_in;
      if (!dir_resp)
         elig = !f[15] && (f & 16'h7a70) == 16'd0 && f[8] && rcz_in == 3'b111 &&
                sq_in[31:16] == 16'd1 && sq_in[15:0] == 16'd1 &&
                {1'b0, udplen_in} - 17'd8 == 17'd16 + {8'd0, nlen_in};
      else
         elig = f[15] && (f & 16'h7a50) == 16'd0 && f[8] &&
                ((f & 16'h000f) == 16'd0 || (f & 16'h000f) == 16'd3) && rcz_in[2] &&
                sq_in[31:16] == 16'd1 && sq_in[15:0] == 16'd1;
      verdict = '0;
      verdict.accepted = (reason == R_NONE);
      verdict.reject_reason = reason;
      if (reason == R_NONE) begin
         verdict.cacheable = elig;
         verdict.transaction_id = sq_in[47:32];
         verdict.query_type = sq_in[31:16];
         verdict.query_class = sq_in[15:0];
         verdict.question_bytes = nlen_in + 9'd4;
      end
      verdict_valid = take && req.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && req.last_byte)) begin
         pos_ff <= '0; phase_ff <= PH_HEADER; err_ff <= R_NONE; shift_ff <= '0;
         mac_ff <= '0; iplen_ff <= '0; udplen_ff <= '0; flags_ff <= '0;
         rcz_ff <= '0; lrem_ff <= '0; nlen_ff <= '0; sq_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in; phase_ff <= phase_in; err_ff <= err_in; shift_ff <= shift_in;
         mac_ff <= mac_in; iplen_ff <= iplen_in; udplen_ff <= udplen_in;
         flags_ff <= flags_in; rcz_ff <= rcz_in; lrem_ff <= lrem_in;
         nlen_ff <= nlen_in; sq_ff <= sq_in;
      end
   end
endmodule

### rtl/core/dns_question_frame_parser_top.sv
`timescale 1ns / 1ps
// The verdict is registered and appears on the response channel in the cycle after the last beat.
// Throughput: one frame byte per cycle unless a held verdict stalls the request side;
// the parse engine updates all frame state in the same cycle a beat is taken, and
// the response register frees itself as soon as it is taken.
// Reset: synchronous, active high; clears frame state, direction to query, port to 53.
module dns_question_frame_parser_top #(
   parameter int MAX_NAME_BYTES = dqfp_pkg::MaxNameBytes
) (
   input logic    clock,
   input logic    reset,
   dqfp_req_if.sink   req,
   dqfp_rsp_if.source rsp,
   dqfp_csr_if.sink   csr
);
   import dqfp_pkg::*;

   // Configuration registers, always writable.
   logic        dir_ff;
   logic [15:0] port_ff;
   req_type     req_bits;
   rsp_type     verdict, rsp_ff;
   logic        vvalid, rvalid_ff, take;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
         port_ff <= DefaultPort;
      end else if (csr.valid) begin
         unique case (csr.index)
            CsrDirection: dir_ff <= csr.wdata[0];
            CsrPort: port_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   // A beat is taken whenever the response slot is empty or being drained;
   // only the last beat of a frame fills it.
   assign req.ready = !rvalid_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign req_bits = '{frame_byte: req.frame_byte, last_byte: req.last_byte};

   dqfp_parse #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_parse (
      .clock(clock), .reset(reset), .take(take), .req(req_bits),
      .dir_resp(dir_ff), .service_port(port_ff),
      .verdict(verdict), .verdict_valid(vvalid)
   );

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else if (vvalid) rvalid_ff <= 1'b1;
      else if (rsp.ready) rvalid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (vvalid) rsp_ff <= verdict;
   end

   assign rsp.valid = rvalid_ff;
   assign rsp.accepted = rsp_ff.accepted;
   assign rsp.reject_reason = rsp_ff.reject_reason;
   assign rsp.cacheable = rsp_ff.cacheable;
   assign rsp.transaction_id = rsp_ff.transaction_id;
   assign rsp.query_type = rsp_ff.query_type;
   assign rsp.query_class = rsp_ff.query_class;
   assign rsp.question_bytes = rsp_ff.question_bytes;
endmodule

### rtl/core/dqfp_checker.sv
`timescale 1ns / 1ps
module dqfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic [3:0] rsp_reason
);
   import dqfp_pkg::*;

   a_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid) else $error("no verdict");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_reason == R_NONE))) else $error("accept flag");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reason <= R_NAMEEND) else $error("reason range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("overrun");
endmodule

bind dns_question_frame_parser_top dqfp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .req_last(req.last_byte), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_accepted(rsp.accepted), .rsp_reason(rsp.reject_reason)
);

### sim/dns_question_frame_parser_top_tb.sv
`timescale 1ns / 1ps
module dns_question_frame_parser_top_tb;
   import dqfp_pkg::*;

   // Frames other than short and noise ones are built from a clean DNS query or response.
   // At most one fault is then applied to each, to reach one particular reject reason.
   typedef enum int {
      F_NONE, F_SHORT, F_MCAST_MAC, F_ZERO_MAC, F_ETHERTYPE, F_IHL, F_FRAGMENT,
      F_PROTOCOL, F_IP_CAST, F_PORT, F_PEER_ZERO, F_IP_LENGTH, F_TRUNCATED,
      F_QDCOUNT, F_COMPRESSED, F_LONG_LABEL, F_TAIL_SHORT, F_EMPTY_NAME,
      F_LONG_NAME, F_NOISE, F_HUGE
   } frame_fault_type;

   typedef struct {
      frame_fault_type fault;
      bit              reason_known;
      reason_type      reason;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dqfp_req_if req();
   dqfp_rsp_if rsp();
   dqfp_csr_if csr();

   dns_question_frame_parser_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   always #5 clock = ~clock;

   // Pacing of the two sides. The sender pauses before a beat with probability
   // sender_gap_pct, and the receiver drops ready with probability sink_stall_pct.
   int unsigned sender_gap_pct = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   // Register values as the stimulus side sees them, used to build matching frames.
   logic        drive_dir = 1'b0;
   logic [15:0] drive_port = DefaultPort;

   // Bytes of the frame that is being built and sent.
   logic [7:0] frame_q[$];

   // Expected verdicts, oldest first, and per frame a reason typed in by hand.
   rsp_type verdict_q[$];
   bit      typed_known_q[$];
   reason_type typed_reason_q[$];

   // ---------------------------------------------------------------------------
   // Parser shadow. It tracks the same per-frame state as the block and works out
   // the verdict on the last beat of every frame.
   // ---------------------------------------------------------------------------
   logic        sh_dir;
   logic [15:0] sh_port;
   int unsigned sh_pos;
   phase_type   sh_phase;
   reason_type  sh_error;
   logic [31:0] sh_shift;
   logic [1:0]  sh_mac_seen;
   logic [15:0] sh_ip_len;
   logic [15:0] sh_udp_len;
   logic [15:0] sh_flags;
   logic [2:0]  sh_counts_zero;
   logic [5:0]  sh_label_left;
   int unsigned sh_name_len;
   logic [47:0] sh_question;

   function automatic void clear_shadow_frame();
      sh_pos = 0;
      sh_phase = PH_HEADER;
      sh_error = R_NONE;
      sh_shift = '0;
      sh_mac_seen = '0;
      sh_ip_len = '0;
      sh_udp_len = '0;
      sh_flags = '0;
      sh_counts_zero = '0;
      sh_label_left = '0;
      sh_name_len = 0;
      sh_question = '0;
   endfunction

   function automatic void note_error(reason_type code);
      if (sh_error == R_NONE)
         sh_error = code;
   endfunction

   function automatic bit is_unicast_ip(logic [31:0] a);
      return a != 32'h0 && (a < 32'he0000000 || a > 32'hefffffff) && a != 32'hffffffff;
   endfunction

   function automatic void grow_name();
      if (sh_name_len < NameLenLimit)
         sh_name_len++;
   endfunction

   // One byte of the DNS message, at offset off of a payload of size bytes.
   function automatic void parse_dns_byte(int unsigned off, int unsigned size,
                                          logic [7:0] b);
      logic [15:0] w;
      int unsigned left;
      w = sh_shift[15:0];
      left = size - (off + 1);
      if (off < 12) begin
         case (off)
            1: sh_question = {w, 32'h0};
            3: sh_flags = w;
            5: if (w != 16'd1) note_error(R_QDCOUNT);
            7: if (w == 16'd0) sh_counts_zero[0] = 1'b1;
            9: if (w == 16'd0) sh_counts_zero[1] = 1'b1;
            11: begin
               if (w == 16'd0) sh_counts_zero[2] = 1'b1;
               sh_phase = PH_LENGTH;
            end
            default: ;
         endcase
         return;
      end
      case (sh_phase)
         PH_LENGTH: begin
            grow_name();
            if ((b & 8'hc0) != 0) begin
               note_error(R_LABEL);
               sh_phase = PH_STOP;
            end else if (b == 0) begin
               if (left < 4 || sh_name_len > MaxNameBytes) begin
                  note_error(R_NAMEEND);
                  sh_phase = PH_STOP;
               end else begin
                  sh_label_left = 6'd4;
                  sh_phase = PH_TAIL;
               end
            end else if (b > left) begin
               note_error(R_LABEL);
               sh_phase = PH_STOP;
            end else begin
               sh_label_left = b[5:0];
               sh_phase = PH_LABEL;
            end
         end
         PH_LABEL: begin
            grow_name();
            sh_label_left = sh_label_left - 6'd1;
            if (sh_label_left == 0)
               sh_phase = PH_LENGTH;
         end
         PH_TAIL: begin
            sh_label_left = sh_label_left - 6'd1;
            if (sh_label_left == 0) begin
               sh_question[31:0] = sh_shift;
               sh_phase = PH_COMPLETE;
            end
         end
         default: ;
      endcase
   endfunction

   // One byte at frame position pos: header checks below the DNS start, then the
   // DNS message as long as it lies inside the UDP payload.
   function automatic void parse_frame_byte(int unsigned pos, logic [7:0] b);
      logic [15:0] w;
      bit port_bad;
      sh_shift = {sh_shift[23:0], b};
      w = sh_shift[15:0];
      if (pos < DnsStart) begin
         if ((pos == 0 || pos == 6) && b[0]) note_error(R_ETH);
         if (pos < 6 && b != 0) sh_mac_seen[0] = 1'b1;
         if (pos >= 6 && pos < 12 && b != 0) sh_mac_seen[1] = 1'b1;
         if (pos == 11 && sh_mac_seen != 2'b11) note_error(R_ETH);
         if (pos == 13 && w != 16'h0800) note_error(R_ETH);
         if (pos == 14 && b != 8'h45) note_error(R_IPHDR);
         if (pos == 17) sh_ip_len = w;
         if (pos == 21 && (w & 16'h3fff) != 0) note_error(R_IPHDR);
         if (pos == 23 && b != 8'd17) note_error(R_IPHDR);
         if ((pos == 29 || pos == 33) && !sh_dir && !is_unicast_ip(sh_shift))
            note_error(R_CAST);
         if (pos == 37) begin
            if (!sh_dir)
               port_bad = w != sh_port || sh_shift[31:16] == 0;
            else
               port_bad = sh_shift[31:16] != sh_port || w == 0;
            if (port_bad) note_error(R_PORT);
         end
         if (pos == 39) begin
            sh_udp_len = w;
            if (int'(sh_ip_len) != 20 + int'(sh_udp_len) || sh_udp_len < 16'd20)
               note_error(R_LENGTH);
         end
         return;
      end
      if (sh_error == R_NONE && pos - DnsStart < int'(sh_udp_len) - 8)
         parse_dns_byte(pos - DnsStart, int'(sh_udp_len) - 8, b);
   endfunction

   function automatic bit cache_eligible();
      logic [15:0] f;
      bit in_a;
      f = sh_flags;
      in_a = sh_question[31:16] == 16'd1 && sh_question[15:0] == 16'd1;
      if (!sh_dir)
         return !f[15] && (f & 16'h7a70) == 0 && f[8] && sh_counts_zero == 3'b111 && in_a
            && int'(sh_udp_len) - 8 == 12 + sh_name_len + 4;
      return f[15] && (f & 16'h7a50) == 0 && f[8] && (f[3:0] == 4'd0 || f[3:0] == 4'd3)
         && sh_counts_zero[2] && in_a;
   endfunction

   // Takes one beat; returns 1 with the verdict when the beat closes a frame.
   function automatic bit predict_beat(logic [7:0] b, logic last, output rsp_type verdict);
      reason_type why;
      verdict = '0;
      if (sh_pos < PosLimit) begin
         parse_frame_byte(sh_pos, b);
         sh_pos++;
      end
      if (!last)
         return 1'b0;
      if (sh_pos < DnsStart) why = R_SHORT;
      else if (sh_error != R_NONE && sh_error < R_QDCOUNT) why = sh_error;
      else if (34 + int'(sh_udp_len) > sh_pos) why = R_LENGTH;
      else if (sh_error != R_NONE) why = sh_error;
      else if (sh_phase != PH_COMPLETE) why = R_NAMEEND;
      else why = R_NONE;
      verdict.reject_reason = why;
      if (why == R_NONE) begin
         verdict.accepted = 1'b1;
         verdict.cacheable = cache_eligible();
         verdict.transaction_id = sh_question[47:32];
         verdict.query_type = sh_question[31:16];
         verdict.query_class = sh_question[15:0];
         verdict.question_bytes = 9'(sh_name_len + 4);
      end
      clear_shadow_frame();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Observation. All channels are sampled at the rising edge, where the values
   // driven in the previous cycle are still in place.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type verdict;
      rsp_type want;
      bit known;
      reason_type typed;
      if (reset) begin
         sh_dir <= 1'b0;
         sh_port <= DefaultPort;
         clear_shadow_frame();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CsrDirection)
               sh_dir <= csr.wdata[0];
            else
               sh_port <= csr.wdata;
         end
         if (req.valid && req.ready)
            if (predict_beat(req.frame_byte, req.last_byte, verdict))
               verdict_q.push_back(verdict);
         if (rsp.valid && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with no frame outstanding: reason %0d", rsp.reject_reason);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               known = typed_known_q.pop_front();
               typed = typed_reason_q.pop_front();
               if (known && rsp.reject_reason != typed) begin
                  $error("reject_reason (typed): expected %0d, got %0d", typed,
                         rsp.reject_reason);
                  fail_count++;
               end
               if (rsp.accepted != want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp.accepted);
                  fail_count++;
               end
               if (rsp.reject_reason != want.reject_reason) begin
                  $error("reject_reason: expected %0d, got %0d", want.reject_reason,
                         rsp.reject_reason);
                  fail_count++;
               end
               if (rsp.cacheable != want.cacheable) begin
                  $error("cacheable: expected %0d, got %0d", want.cacheable, rsp.cacheable);
                  fail_count++;
               end
               if (rsp.transaction_id != want.transaction_id) begin
                  $error("transaction_id: expected %h, got %h", want.transaction_id,
                         rsp.transaction_id);
                  fail_count++;
               end
               if (rsp.query_type != want.query_type) begin
                  $error("query_type: expected %h, got %h", want.query_type, rsp.query_type);
                  fail_count++;
               end
               if (rsp.query_class != want.query_class) begin
                  $error("query_class: expected %h, got %h", want.query_class,
                         rsp.query_class);
                  fail_count++;
               end
               if (rsp.question_bytes != want.question_bytes) begin
                  $error("question_bytes: expected %0d, got %0d", want.question_bytes,
                         rsp.question_bytes);
                  fail_count++;
               end
            end
         end
      end
   end

   // The receiver drops ready at random according to the current stall rate.
   always @(posedge clock)
      rsp.ready <= $urandom_range(99) >= sink_stall_pct;

   // The watchdog ends the run if no channel has moved a beat for too long.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------
   task automatic csr_write(logic idx, logic [15:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.wdata <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      if (idx == CsrDirection)
         drive_dir = value[0];
      else
         drive_port = value;
   endtask

   // Holds the sender back until every verdict is in.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_beat(logic [7:0] b, logic last);
      while ($urandom_range(99) < sender_gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.frame_byte <= b;
      req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic void push16(logic [15:0] v);
      frame_q.push_back(v[15:8]);
      frame_q.push_back(v[7:0]);
   endfunction

   function automatic logic [15:0] nonzero16();
      return 16'($urandom_range(65535, 1));
   endfunction

   // Builds a frame for the current direction and port, then applies the fault.
   function automatic void build_frame(frame_fault_type fault);
      logic [7:0] qname[$];
      int unsigned labels, len, udp_len, extra;
      logic [15:0] flags;
      frame_q.delete();
      if (fault == F_SHORT) begin
         repeat ($urandom_range(41, 1)) frame_q.push_back(8'($urandom));
         return;
      end
      if (fault == F_NOISE) begin
         repeat ($urandom_range(90, 1)) frame_q.push_back(8'($urandom));
         return;
      end
      // The question name: four full labels for a long name, else up to three short or full ones.
      if (fault == F_LONG_NAME) begin
         repeat (4) begin
            qname.push_back(8'd63);
            repeat (63) qname.push_back(8'($urandom_range(122, 97)));
         end
      end else if (fault != F_EMPTY_NAME) begin
         labels = $urandom_range(3, 1);
         repeat (labels) begin
            len = ($urandom_range(7) == 0) ? 63 : $urandom_range(12, 1);
            qname.push_back(8'(len));
            repeat (len) qname.push_back(8'($urandom));
         end
      end
      if (fault != F_EMPTY_NAME) qname.push_back(8'h00);
      // Payload bytes past the question would be parsed as name or tail bytes in
      // the short-tail and empty-name cases, so those carry none.
      extra = (fault != F_TAIL_SHORT && fault != F_EMPTY_NAME && $urandom_range(3) == 0)
              ? $urandom_range(3, 1) : 0;
      udp_len = 8 + 12 + qname.size() + extra;
      if (fault != F_EMPTY_NAME) udp_len += 4;
      if (fault == F_TAIL_SHORT) udp_len -= 1;

      // Ethernet: unicast, nonzero addresses of the locally administered kind.
      frame_q.push_back(8'h02);
      repeat (5) frame_q.push_back(8'($urandom));
      frame_q.push_back(8'h06);
      repeat (5) frame_q.push_back(8'($urandom));
      push16(16'h0800);
      // IPv4 header, with the don't-fragment bit set at random.
      frame_q.push_back(8'h45);
      frame_q.push_back(8'($urandom));
      push16(16'(20 + udp_len));
      push16(16'($urandom));
      push16($urandom_range(1) ? 16'h4000 : 16'h0000);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'd17);
      push16(16'($urandom));
      push16(16'h0a00); push16(16'($urandom));
      push16(16'hc0a8); push16(16'($urandom));
      // UDP header: service port on the server side, nonzero peer port.
      if (!drive_dir) begin
         push16(nonzero16()); push16(drive_port);
      end else begin
         push16(drive_port); push16(nonzero16());
      end
      push16(16'(udp_len));
      push16(16'($urandom));
      // DNS header. Half the flag words are the ones a cacheable message carries.
      push16(16'($urandom));
      if ($urandom_range(1))
         flags = !drive_dir ? 16'h0100 : ($urandom_range(1) ? 16'h8180 : 16'h8183);
      else
         flags = 16'($urandom);
      push16(flags);
      push16(16'h0001);
      repeat (3) push16($urandom_range(1) ? 16'h0000 : 16'($urandom));
      foreach (qname[i]) frame_q.push_back(qname[i]);
      if (fault != F_EMPTY_NAME) begin
         if ($urandom_range(1)) begin
            push16(16'h0001); push16(16'h0001);
         end else begin
            push16(16'($urandom)); push16(16'($urandom));
         end
      end
      if (fault == F_TAIL_SHORT) void'(frame_q.pop_back());
      repeat (extra) frame_q.push_back(8'($urandom));
      // Trailing padding, up to the Ethernet minimum and sometimes beyond.
      while (frame_q.size() < 60) frame_q.push_back(8'h00);
      repeat ($urandom_range(4)) frame_q.push_back(8'($urandom));

      case (fault)
         F_MCAST_MAC: frame_q[0][0] = 1'b1;
         F_ZERO_MAC: for (int i = 6; i < 12; i++) frame_q[i] = 8'h00;
         F_ETHERTYPE: frame_q[12] = 8'h86;
         F_IHL: frame_q[14] = 8'h46;
         F_FRAGMENT: frame_q[21] = 8'h01;
         F_PROTOCOL: frame_q[23] = 8'd6;
         F_IP_CAST: frame_q[30] = 8'he0;
         F_PORT: if (!drive_dir) frame_q[37] ^= 8'h01; else frame_q[35] ^= 8'h01;
         F_PEER_ZERO: begin
            if (!drive_dir) begin
               frame_q[34] = 8'h00; frame_q[35] = 8'h00;
            end else begin
               frame_q[36] = 8'h00; frame_q[37] = 8'h00;
            end
         end
         F_IP_LENGTH: frame_q[17] ^= 8'h01;
         F_TRUNCATED: while (frame_q.size() > 34 + udp_len - 1) void'(frame_q.pop_back());
         F_QDCOUNT: frame_q[47] = 8'h02;
         F_COMPRESSED: frame_q[54] = 8'hc0;
         F_LONG_LABEL: frame_q[54] = 8'd63;
         F_HUGE: while (frame_q.size() < 65540) frame_q.push_back(8'($urandom));
         default: ;
      endcase
   endfunction

   task automatic send_frame(frame_fault_type fault, bit known, reason_type reason);
      build_frame(fault);
      typed_known_q.push_back(known);
      typed_reason_q.push_back(reason);
      foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Directed frames, sent with the registers at their reset values. Reasons are
   // typed in where one fault plainly leads to one verdict.
   directed_row_type directed_rows[] = '{
      '{F_NONE, 1, R_NONE}, '{F_SHORT, 1, R_SHORT}, '{F_MCAST_MAC, 1, R_ETH},
      '{F_ZERO_MAC, 1, R_ETH}, '{F_ETHERTYPE, 1, R_ETH}, '{F_IHL, 1, R_IPHDR},
      '{F_FRAGMENT, 1, R_IPHDR}, '{F_PROTOCOL, 1, R_IPHDR}, '{F_IP_CAST, 1, R_CAST},
      '{F_PORT, 1, R_PORT}, '{F_PEER_ZERO, 1, R_PORT}, '{F_IP_LENGTH, 1, R_LENGTH},
      '{F_TRUNCATED, 1, R_LENGTH}, '{F_QDCOUNT, 1, R_QDCOUNT},
      '{F_COMPRESSED, 1, R_LABEL}, '{F_LONG_LABEL, 0, R_NONE},
      '{F_TAIL_SHORT, 1, R_NAMEEND}, '{F_EMPTY_NAME, 1, R_NAMEEND},
      '{F_LONG_NAME, 1, R_NAMEEND}, '{F_NOISE, 0, R_NONE}, '{F_HUGE, 1, R_NONE}
   };

   // Random phases: register settings, extremes included, and pacing of both sides.
   logic [15:0] phase_ports[8] = '{16'd53, 16'd0, 16'd65535, 16'd53, 16'd8053, 16'd1,
                                   16'd65535, 16'd0};
   int unsigned phase_gaps[8] = '{0, 52, 0, 23, 0, 52, 0, 23};
   int unsigned phase_stalls[8] = '{0, 0, 52, 23, 0, 0, 52, 23};

   initial begin
      frame_fault_type fault;
      req.valid = 1'b0;
      req.frame_byte = '0;
      req.last_byte = 1'b0;
      csr.valid = 1'b0;
      csr.index = CsrDirection;
      csr.wdata = '0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_frame(directed_rows[i].fault, directed_rows[i].reason_known,
                    directed_rows[i].reason);

      for (int p = 0; p < 8; p++) begin
         // Registers change only once the parser has gone quiet.
         drain();
         csr_write(CsrDirection, 16'(p % 2));
         csr_write(CsrPort, phase_ports[p]);
         sender_gap_pct = phase_gaps[p];
         sink_stall_pct = phase_stalls[p];
         repeat (9) begin
            // Mostly well-formed frames with random content, the rest faulty or noise.
            if ($urandom_range(99) < 55)
               fault = F_NONE;
            else
               fault = frame_fault_type'($urandom_range(F_NOISE, F_SHORT));
            send_frame(fault, 0, R_NONE);
         end
      end

      drain();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
